### hw/rtl/bmhq_pkg.sv
// Shared types and constants for the binary min-heap priority queue.
// Holds the beat structs, the memory request struct and the opcode and status codes.
// Depends on nothing; every other file imports it.
package bmhq_pkg;

  // Heap geometry.
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  // A heap position runs 1..CAPACITY, so it needs one more bit than an address.
  localparam int POS_W    = ADDR_W + 1;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = 11;

  // Opcodes of an input beat.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Status codes of a result beat.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                    op;
    logic signed [KEY_W-1:0] key;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] removed_key;
    logic signed [KEY_W-1:0] top_key;
    logic                    top_valid;
    logic [CNT_W-1:0]        entry_count;
  } out_beat_t;

  // One write and two reads per cycle on the heap memory.
  typedef struct packed {
    logic                    we;
    logic [ADDR_W-1:0]       waddr;
    logic signed [KEY_W-1:0] wdata;
    logic [ADDR_W-1:0]       raddr_a;
    logic [ADDR_W-1:0]       raddr_b;
  } mem_req_t;

endpackage

### hw/rtl/bmhq_ram.sv
// Heap storage: one write port and two read ports with registered read data.
// Depends on bmhq_pkg for the geometry and the request struct.
// Entries hold no reset value; only written entries are ever used.
module bmhq_ram
  import bmhq_pkg::*;
(
  input  logic                    clk,
  input  mem_req_t                req,
  output logic signed [KEY_W-1:0] rd_a,
  output logic signed [KEY_W-1:0] rd_b
);

  logic signed [KEY_W-1:0] mem [CAPACITY];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Two read ports with registered read data.
  always_ff @(posedge clk) begin
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

endmodule

### hw/rtl/bmhq_ctrl.sv
// Sequencer for the heap: accepts a command, walks the sift up or sift down
// over the heap memory, and presents one result. Depends on bmhq_pkg.
// The entry being moved stays in a register and is written once at its final place.
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_beat_t                in_data,
  output logic                    res_valid,
  input  logic                    res_ready,
  output out_beat_t               res,
  output mem_req_t                mem_req,
  input  logic signed [KEY_W-1:0] rd_a,
  input  logic signed [KEY_W-1:0] rd_b
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LAST   = 3'd1;
  localparam logic [2:0] S_UP_RD  = 3'd2;
  localparam logic [2:0] S_UP_CMP = 3'd3;
  localparam logic [2:0] S_DN_RD  = 3'd4;
  localparam logic [2:0] S_DN_CMP = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]              state_r, state_nxt;
  logic [POS_W-1:0]        count_r, count_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic signed [KEY_W-1:0] val_r, val_nxt;
  logic signed [KEY_W-1:0] top_r, top_nxt;
  logic signed [KEY_W-1:0] removed_r, removed_nxt;
  logic [1:0]              status_r, status_nxt;

  // Child and parent positions of the current position.
  logic [POS_W:0]          left_pos, right_pos, count_ext;
  logic [POS_W-1:0]        parent_pos;
  logic                    has_right, take_right, do_swap;
  logic signed [KEY_W-1:0] child_val;

  assign count_ext  = {1'b0, count_r};
  assign left_pos   = {pos_r, 1'b0};
  assign right_pos  = left_pos + (POS_W+1)'(1);
  assign parent_pos = pos_r >> 1;

  // Pick the smaller child; equal children take the right one.
  assign has_right  = (right_pos <= count_ext);
  assign take_right = has_right && !(rd_a < rd_b);
  assign child_val  = take_right ? rd_b : rd_a;
  assign do_swap    = (child_val < val_r);

  assign in_ready = (state_r == S_IDLE);

  // Next-state and datapath logic.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    top_nxt     = top_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    mem_req     = '0;
    res_valid   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // Read the last entry ahead of a dequeue.
        mem_req.raddr_a = ADDR_W'(count_r - POS_W'(1));
        if (in_valid) begin
          removed_nxt = '0;
          status_nxt  = ST_OK;
          if (in_data.op == OP_ENQ) begin
            if (count_r >= POS_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              count_nxt = count_r + POS_W'(1);
              pos_nxt   = count_r + POS_W'(1);
              val_nxt   = in_data.key;
              state_nxt = (count_r == '0) ? S_FIN : S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              removed_nxt = top_r;
              count_nxt   = count_r - POS_W'(1);
              state_nxt   = S_LAST;
            end
          end
        end
      end

      S_LAST: begin
        // The last entry moves to the root and sinks from there.
        val_nxt   = rd_a;
        pos_nxt   = POS_W'(1);
        state_nxt = S_DN_RD;
      end

      S_UP_RD: begin
        mem_req.raddr_a = ADDR_W'(parent_pos - POS_W'(1));
        state_nxt       = S_UP_CMP;
      end

      S_UP_CMP: begin
        // Move the parent down while the new key is strictly smaller.
        if (val_r < rd_a) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ADDR_W'(pos_r - POS_W'(1));
          mem_req.wdata = rd_a;
          pos_nxt       = parent_pos;
          state_nxt     = (parent_pos == POS_W'(1)) ? S_FIN : S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_DN_RD: begin
        mem_req.raddr_a = ADDR_W'(left_pos - (POS_W+1)'(1));
        mem_req.raddr_b = ADDR_W'(left_pos);
        state_nxt       = (left_pos > count_ext) ? S_FIN : S_DN_CMP;
      end

      S_DN_CMP: begin
        // Lift the smaller child while it is below the sinking entry.
        if (do_swap) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ADDR_W'(pos_r - POS_W'(1));
          mem_req.wdata = child_val;
          if (pos_r == POS_W'(1)) begin
            top_nxt = child_val;
          end
          pos_nxt   = take_right ? POS_W'(right_pos) : POS_W'(left_pos);
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        // The moving entry lands at its final position.
        mem_req.we    = 1'b1;
        mem_req.waddr = ADDR_W'(pos_r - POS_W'(1));
        mem_req.wdata = val_r;
        if (pos_r == POS_W'(1)) begin
          top_nxt = val_r;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result fields, built from the state after the operation.
  always_comb begin
    res.status      = status_r;
    res.removed_key = removed_r;
    res.top_valid   = (count_r != '0);
    res.top_key     = (count_r != '0) ? top_r : '0;
    res.entry_count = CNT_W'(count_r);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    top_r     <= top_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
  end

endmodule

### hw/rtl/binary_min_heap_queue.sv
// Channel  Direction  Ports                          Beat
// in       input      in_valid, in_ready, in_data    in_beat_t  (op, key)
// out      output     out_valid, out_ready, out_data out_beat_t (status, keys, count)
//
// Top level of the heap priority queue: sequencer, heap memory and result register.
// Depends on bmhq_pkg, bmhq_ram and bmhq_ctrl.
// An enqueue sifts the new key up and a dequeue moves the last entry to the root and
// sinks it, one level at a time; at 1024 entries an entry moves at most 10 levels.
// Each level is one read of the heap memory and one compare with write-back. Error
// beats go straight to the result.
// Reset is synchronous and active low; it empties the queue at once, with no
// clearing pass. A new command is taken while the previous result waits in the
// output register; a stalled output holds the sequencer only at its final step.
module binary_min_heap_queue
  import bmhq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  mem_req_t                mem_req;
  logic signed [KEY_W-1:0] rd_a, rd_b;
  logic                    res_valid, res_ready;
  out_beat_t               res;
  logic                    out_valid_r;
  out_beat_t               out_data_r;

  bmhq_ram u_ram (
    .clk  (clk),
    .req  (mem_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  // Output register: loads when empty or when its beat leaves.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The sequencer leaves idle right after taking a command.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second command without doing the first");

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The valid flag of the minimum tracks a nonzero count.
  a_top_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.top_valid == (out_data.entry_count != '0))
    else $error("top_valid disagrees with entry_count");

  // A rejected command removes nothing.
  a_err_no_removal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.removed_key == '0)
    else $error("error beat carries a removed key");

endmodule

### sim/tb_top.sv
// Testbench for binary_min_heap_queue: random enqueue and dequeue beats checked
// against a heap predictor, covering empty and full queues, equal and extreme keys.
// Depends on bmhq_pkg and the binary_min_heap_queue RTL.
`timescale 1ns / 100ps

module tb_top;
  import bmhq_pkg::*;

  // Cycles with no beat on either channel before the run is declared hung.
  localparam int HANG_LIMIT   = 4000;
  // Cycles to wait after the last result for any stray beat.
  localparam int TAIL_CYCLES  = 64;
  localparam int MAX_PRINTS   = 30;

  typedef struct {
    in_beat_t beat;
    bit       drain_first;
  } cmd_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  // Commands waiting to be sent, and results the heap should still produce.
  cmd_t      cmd_q[$];
  out_beat_t result_q[$];

  // Predictor state: a 1-indexed heap and its fill level.
  logic signed [KEY_W-1:0] pq_heap [1:CAPACITY];
  int unsigned             pq_size  = 0;
  int unsigned             gen_fill = 0;

  bit  in_took      = 1'b0;
  int  in_accepted  = 0;
  int  err_cnt      = 0;
  int  hang_cnt     = 0;
  int  gap_left     = 0;
  int  burst_left   = 1;
  int  hold_left    = 0;
  int  holds_done   = 0;
  int  rx_mode      = 0;
  int  rx_phase     = 0;

  binary_min_heap_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void pq_swap(input int unsigned a, input int unsigned b);
    logic signed [KEY_W-1:0] tmp;
    tmp        = pq_heap[a];
    pq_heap[a] = pq_heap[b];
    pq_heap[b] = tmp;
  endfunction

  // Apply one command to the predicted heap and return the result beat it should give.
  function automatic out_beat_t pq_apply(input in_beat_t beat);
    out_beat_t   res;
    int unsigned pos;
    int unsigned lc;
    int unsigned rc;
    bit          moving;
    res        = '0;
    res.status = ST_OK;
    if (beat.op == OP_ENQ) begin
      if (pq_size >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        pq_size++;
        pos          = pq_size;
        pq_heap[pos] = beat.key;
        // Sift up while strictly smaller than the parent.
        while (pos > 1 && pq_heap[pos] < pq_heap[pos / 2]) begin
          pq_swap(pos, pos / 2);
          pos = pos / 2;
        end
      end
    end else if (pq_size == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.removed_key = pq_heap[1];
      pq_heap[1]      = pq_heap[pq_size];
      pq_size--;
      pos    = 1;
      moving = 1'b1;
      // Sift down; equal children send the entry to the right.
      while (moving && 2 * pos <= pq_size) begin
        lc = 2 * pos;
        rc = lc + 1;
        if (rc > pq_size) begin
          if (pq_heap[pos] > pq_heap[lc]) pq_swap(pos, lc);
          moving = 1'b0;
        end else if (pq_heap[lc] < pq_heap[pos] || pq_heap[rc] < pq_heap[pos]) begin
          if (pq_heap[lc] < pq_heap[rc]) begin
            pq_swap(pos, lc);
            pos = lc;
          end else begin
            pq_swap(pos, rc);
            pos = rc;
          end
        end else begin
          moving = 1'b0;
        end
      end
    end
    if (pq_size != 0) begin
      res.top_key   = pq_heap[1];
      res.top_valid = 1'b1;
    end
    res.entry_count = CNT_W'(pq_size);
    return res;
  endfunction

  task automatic flag_error(input string msg);
    if (err_cnt < MAX_PRINTS) $display("%0t mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Queue one command and track the fill level it leads to.
  task automatic add_cmd(input logic op, input logic signed [KEY_W-1:0] key,
                         input bit drain_first = 1'b0);
    cmd_t c;
    c.beat.op     = op;
    c.beat.key    = key;
    c.drain_first = drain_first;
    cmd_q = {cmd_q, c};
    if (op == OP_ENQ && gen_fill < CAPACITY) gen_fill++;
    else if (op == OP_DEQ && gen_fill > 0) gen_fill--;
  endtask

  // Keys are full range, a narrow band that repeats often, an extreme, or zero or minus one.
  function automatic logic signed [KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom;
    if (sel < 8) return $signed($urandom_range(0, 16)) - 8;
    if (sel == 8) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $urandom_range(0, 1) ? 32'sh0000_0000 : -32'sd1;
  endfunction

  // Sample both channels at the rising edge: check results, predict accepted commands.
  always @(posedge clk) begin : monitor
    out_beat_t want;
    in_took = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          flag_error("result beat with nothing expected");
        end else begin
          want = result_q.pop_front();
          if (out_data.status !== want.status)
            flag_error($sformatf("status got %0d want %0d", out_data.status, want.status));
          if (out_data.removed_key !== want.removed_key)
            flag_error($sformatf("removed_key got %0d want %0d",
                                 out_data.removed_key, want.removed_key));
          if (out_data.top_key !== want.top_key)
            flag_error($sformatf("top_key got %0d want %0d", out_data.top_key, want.top_key));
          if (out_data.top_valid !== want.top_valid)
            flag_error($sformatf("top_valid got %0d want %0d",
                                 out_data.top_valid, want.top_valid));
          if (out_data.entry_count !== want.entry_count)
            flag_error($sformatf("entry_count got %0d want %0d",
                                 out_data.entry_count, want.entry_count));
        end
      end
      if (in_valid && in_ready) begin
        want     = pq_apply(in_data);
        result_q = {result_q, want};
        in_accepted++;
        in_took = 1'b1;
      end
    end
  end

  // Hang detection: cycles in which neither channel moves a beat.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) hang_cnt = 0;
    else hang_cnt++;
    if (hang_cnt >= HANG_LIMIT) begin
      $display("[binary_min_heap_queue] ERROR");
      $finish;
    end
  end

  // Sender: bursts of commands separated by random gaps, with an optional drain first.
  always @(negedge clk) begin : driver
    logic     nv;
    in_beat_t nd;
    nv = in_valid;
    nd = in_data;
    if (in_took) begin
      void'(cmd_q.pop_front());
      nv = 1'b0;
    end
    if (!nv && rst_n && cmd_q.size() != 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (!(cmd_q[0].drain_first && result_q.size() != 0)) begin
        nv = 1'b1;
        nd = cmd_q[0].beat;
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(150, 300);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left   = $urandom_range(1, 12);
          end
        end
      end
    end
    in_valid <= nv;
    in_data  <= nd;
  end

  // Receiver: phases of full speed, light and heavy stalling, plus two long hold-offs.
  always @(negedge clk) begin : receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if ((holds_done == 0 && in_accepted >= 300) ||
                 (holds_done == 1 && in_accepted >= 1100)) begin
      holds_done++;
      hold_left = 400;
      out_ready <= 1'b0;
    end else begin
      if (rx_phase <= 0) begin
        rx_mode  = $urandom_range(0, 2);
        rx_phase = $urandom_range(20, 200);
      end
      rx_phase--;
      case (rx_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_ready <= ($urandom_range(0, 4) == 0);
        end
      endcase
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int n;
    // Directed: empty queue, extreme keys, equal keys and equal children.
    add_cmd(OP_DEQ, 32'shFFFF_FFFF);
    add_cmd(OP_ENQ, 32'sd0);
    add_cmd(OP_ENQ, 32'sh7FFF_FFFF);
    add_cmd(OP_ENQ, 32'sh8000_0000);
    add_cmd(OP_ENQ, -32'sd1);
    add_cmd(OP_ENQ, 32'sd1);
    add_cmd(OP_ENQ, 32'sd5);
    add_cmd(OP_ENQ, 32'sd5);
    add_cmd(OP_ENQ, 32'sd5);
    for (n = 0; n < 9; n++) add_cmd(OP_DEQ, 32'sd0);
    add_cmd(OP_ENQ, 32'sd2);
    add_cmd(OP_ENQ, 32'sd4);
    add_cmd(OP_ENQ, 32'sd4);
    add_cmd(OP_ENQ, 32'sd9);
    add_cmd(OP_DEQ, 32'sh5555_5555);
    add_cmd(OP_DEQ, 32'shAAAA_AAAA);

    // Mixed traffic around small sizes; the sender first waits for the heap to go quiet.
    add_cmd(OP_ENQ, pick_key(), 1'b1);
    for (n = 0; n < 150; n++) add_cmd(1'($urandom_range(0, 1)), pick_key());

    // Fill to capacity with a few dequeues mixed in, then push against the full queue.
    while (gen_fill < CAPACITY) begin
      if ($urandom_range(0, 99) < 93) add_cmd(OP_ENQ, pick_key());
      else add_cmd(OP_DEQ, pick_key());
    end
    for (n = 0; n < 4; n++) add_cmd(OP_ENQ, pick_key());
    add_cmd(OP_DEQ, pick_key());
    add_cmd(OP_ENQ, pick_key());
    add_cmd(OP_ENQ, pick_key());

    // Deep removals from a nearly full heap.
    for (n = 0; n < 100; n++)
      add_cmd(($urandom_range(0, 9) < 7) ? OP_DEQ : OP_ENQ, pick_key());

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || in_valid) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("[binary_min_heap_queue] OK");
    end else begin
      $display("[binary_min_heap_queue] ERROR");
    end
    $finish;
  end

endmodule
